@@ rtl/core/window_min_range_square_assert.svh @@
// Assertion macros shared by the window min/max range checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef WINDOW_MIN_RANGE_SQUARE_ASSERT_SVH
`define WINDOW_MIN_RANGE_SQUARE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMRS_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("window_min_range_square: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WMRS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("window_min_range_square: next-cycle check failed");

`endif

@@ rtl/core/wmrs_pkg.sv @@
// Package for the window min/max range block: payload structs, item flags,
// register indexes and fixed constants. No dependencies.
package wmrs_pkg;

  localparam int PIX_W      = 31;
  localparam int ROWS_W     = 16;
  localparam int COLS_W     = 11;
  localparam int WIN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PIX_W-1:0] RANGE_TOP = 31'h7fff_ffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS  = 2'd0,
    REG_FRAME_COLS  = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] window_range;
    logic [PIX_W-1:0] best_range;
    logic             frame_done;
  } res_out_t;

  typedef struct packed {
    logic v_do;
    logic h_do;
    logic last;
    logic rst_best;
    logic wrap;
  } item_flags_t;

endpackage

@@ rtl/core/wmrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module wmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/wmrs_minmax_tree.sv @@
// Registered max/min reduction tree with a matching sideband delay line.
// Depends on nothing; one register level per halving of the input count.
module wmrs_minmax_tree #(
  parameter int N   = 16,
  parameter int W   = 31,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [W-1:0]   max_i [N],
  input  logic [W-1:0]   min_i [N],
  input  logic [SBW-1:0] sb_i,
  output logic [W-1:0]   max_o,
  output logic [W-1:0]   min_o,
  output logic [SBW-1:0] sb_o
);

  localparam int LV = $clog2(N);

  if (LV == 0) begin : g_flat
    assign max_o = max_i[0];
    assign min_o = min_i[0];
    assign sb_o  = sb_i;
  end else begin : g_tree
    logic [W-1:0]   mx_q    [N-1];
    logic [W-1:0]   mn_q    [N-1];
    logic [W-1:0]   node_mx [2*N-1];
    logic [W-1:0]   node_mn [2*N-1];
    logic [SBW-1:0] sb_q    [LV];

    always_comb begin
      for (int k = 0; k < N-1; k++) begin
        node_mx[k] = mx_q[k];
        node_mn[k] = mn_q[k];
      end
      for (int k = 0; k < N; k++) begin
        node_mx[k+N-1] = max_i[k];
        node_mn[k+N-1] = min_i[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < N-1; i++) begin
          mx_q[i] <= (node_mx[2*i+1] > node_mx[2*i+2]) ? node_mx[2*i+1] : node_mx[2*i+2];
          mn_q[i] <= (node_mn[2*i+1] < node_mn[2*i+2]) ? node_mn[2*i+1] : node_mn[2*i+2];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int s = 0; s < LV; s++) begin
          sb_q[s] <= '0;
        end
      end else if (en_i) begin
        sb_q[0] <= sb_i;
        for (int s = 1; s < LV; s++) begin
          sb_q[s] <= sb_q[s-1];
        end
      end
    end

    assign max_o = mx_q[0];
    assign min_o = mn_q[0];
    assign sb_o  = sb_q[LV-1];
  end

endmodule

@@ rtl/core/window_min_range_square.sv @@
// Throughput: one pixel per cycle while the output is not stalled, set by one
// read-modify-write of the column word in the line store per pixel, with forwarding
// when consecutive pixels share a column.
// Reset: registers return to 1, position to zero, column extremes to zero and the best
// range to all ones; the line store is not cleared and needs no clearing pass.
module window_min_range_square import wmrs_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_WINDOW = 16,
  parameter int PIXEL_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_out_t              out_data_o
);

  localparam int PW  = (PIXEL_BITS > PIX_W) ? PIX_W : PIXEL_BITS;
  localparam int LB  = $clog2(MAX_WINDOW);
  localparam int L   = 1 << LB;
  localparam int SW  = (LB > 0) ? LB : 1;
  localparam int CB  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WB  = $clog2(MAX_WINDOW + 1);

  typedef struct packed {
    logic [CB-1:0] col;
    logic [SW-1:0] slot;
    logic [SW-1:0] cslot;
    logic [PW-1:0] px;
    item_flags_t   flags;
  } s1_t;

  typedef struct packed {
    logic          valid;
    logic [SW-1:0] cslot;
    item_flags_t   flags;
  } vsb_t;

  typedef struct packed {
    logic        valid;
    item_flags_t flags;
  } hsb_t;

  logic [ROWS_W-1:0] frame_rows_q;
  logic [COLS_W-1:0] frame_cols_q;
  logic [WIN_W-1:0]  window_size_q;

  logic [ROWS_W-1:0] r_q;
  logic [CB-1:0]     c_q;
  logic              s1_valid_q;
  s1_t               s1_q;
  logic              fwd_valid_q;
  logic [CB-1:0]     fwd_addr_q;
  logic [L*PW-1:0]   fwd_word_q;
  logic [PW-1:0]     col_max_q [L];
  logic [PW-1:0]     col_min_q [L];
  logic [PIX_W-1:0]  best_q;
  logic              out_valid_q;
  res_out_t          out_q;

  logic              advance;
  logic              accept;
  logic [ROWS_W-1:0] rows_eff;
  logic [ROWS_W-1:0] rows_m1;
  logic [15:0]       cols_eff;
  logic [CB-1:0]     cols_m1;
  logic [7:0]        w_ext;
  logic [WB-1:0]     w_eff;
  logic [ROWS_W-1:0] r_start;
  logic [CB-1:0]     c_start;
  logic [ROWS_W-1:0] r_cur;
  logic [CB-1:0]     c_cur;
  logic              last_col;
  logic              last_row;
  item_flags_t       in_flags;

  logic [L*PW-1:0]   ram_rdata;
  logic [L*PW-1:0]   rd_word;
  logic [L*PW-1:0]   wr_word;
  logic              fwd_hit;
  logic              lstore_we;
  logic [PW-1:0]     vmax_in [L];
  logic [PW-1:0]     vmin_in [L];
  vsb_t              vsb_in;
  logic [PW-1:0]     vmax_v;
  logic [PW-1:0]     vmin_v;
  vsb_t              vsb_out;
  logic [PW-1:0]     hmax_in [L];
  logic [PW-1:0]     hmin_in [L];
  hsb_t              hsb_in;
  logic [PW-1:0]     hmax_h;
  logic [PW-1:0]     hmin_h;
  hsb_t              hsb_out;
  logic [PW-1:0]     diff;
  logic [PIX_W-1:0]  range_val;
  logic [PIX_W-1:0]  best_base;
  logic [PIX_W-1:0]  best_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q  <= ROWS_W'(1);
      frame_cols_q  <= COLS_W'(1);
      window_size_q <= WIN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_ROWS:  frame_rows_q  <= cfg_wdata_i[ROWS_W-1:0];
        REG_FRAME_COLS:  frame_cols_q  <= cfg_wdata_i[COLS_W-1:0];
        REG_WINDOW_SIZE: window_size_q <= cfg_wdata_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (frame_rows_q == '0) ? ROWS_W'(1) : frame_rows_q;
    rows_m1  = rows_eff - ROWS_W'(1);
    cols_eff = 16'(frame_cols_q);
    if (cols_eff == 16'd0) begin
      cols_eff = 16'd1;
    end else if (cols_eff > 16'(MAX_COLS)) begin
      cols_eff = 16'(MAX_COLS);
    end
    cols_m1 = CB'(cols_eff - 16'd1);
    w_ext   = 8'(window_size_q);
    if (w_ext == 8'd0) begin
      w_ext = 8'd1;
    end else if (w_ext > 8'(MAX_WINDOW)) begin
      w_ext = 8'(MAX_WINDOW);
    end
    w_eff = WB'(w_ext);
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && advance;
  assign in_ready_o = advance;

  always_comb begin
    r_start  = in_data_i.frame_start ? '0 : r_q;
    c_start  = in_data_i.frame_start ? '0 : c_q;
    r_cur    = (r_start > rows_m1) ? rows_m1 : r_start;
    c_cur    = (16'(c_start) >= cols_eff) ? cols_m1 : c_start;
    last_col = (c_cur == cols_m1);
    last_row = (r_cur == rows_m1);
    in_flags.v_do     = (17'(r_cur) + 17'd1) >= 17'(w_eff);
    in_flags.h_do     = in_flags.v_do && ((17'(c_cur) + 17'd1) >= 17'(w_eff));
    in_flags.last     = last_col && last_row;
    in_flags.rst_best = in_data_i.frame_start;
    in_flags.wrap     = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
    end else if (accept) begin
      if (!last_col) begin
        c_q <= c_cur + CB'(1);
        r_q <= r_cur;
      end else if (!last_row) begin
        c_q <= '0;
        r_q <= r_cur + ROWS_W'(1);
      end else begin
        c_q <= '0;
        r_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.col   <= c_cur;
      s1_q.slot  <= SW'(r_cur & ROWS_W'(L-1));
      s1_q.cslot <= SW'(16'(c_cur) & 16'(L-1));
      s1_q.px    <= PW'(in_data_i.pixel);
      s1_q.flags <= in_flags;
    end
  end

  assign lstore_we = s1_valid_q && advance;

  wmrs_ram #(
    .WIDTH (L*PW),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (lstore_we),
    .waddr_i (s1_q.col),
    .wdata_i (wr_word),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (ram_rdata)
  );

  // The previous write may target the same column word before the RAM shows it.
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_q.col);
  assign rd_word = fwd_hit ? fwd_word_q : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (lstore_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lstore_we) begin
      fwd_addr_q <= s1_q.col;
      fwd_word_q <= wr_word;
    end
  end

  always_comb begin
    logic [PW-1:0] lane;
    logic [SW-1:0] ofs;
    logic          inc;
    for (int j = 0; j < L; j++) begin
      lane = (SW'(j) == s1_q.slot) ? s1_q.px : rd_word[j*PW +: PW];
      wr_word[j*PW +: PW] = lane;
      ofs = s1_q.slot - SW'(j);
      inc = (SW+WB)'(ofs) < (SW+WB)'(w_eff);
      vmax_in[j] = inc ? lane : '0;
      vmin_in[j] = inc ? lane : '1;
    end
  end

  assign vsb_in = '{valid: s1_valid_q, cslot: s1_q.cslot, flags: s1_q.flags};

  wmrs_minmax_tree #(
    .N   (L),
    .W   (PW),
    .SBW ($bits(vsb_t))
  ) u_vert_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .max_i  (vmax_in),
    .min_i  (vmin_in),
    .sb_i   (vsb_in),
    .max_o  (vmax_v),
    .min_o  (vmin_v),
    .sb_o   (vsb_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < L; j++) begin
        col_max_q[j] <= '0;
        col_min_q[j] <= '0;
      end
    end else if (advance && vsb_out.valid && vsb_out.flags.v_do) begin
      col_max_q[vsb_out.cslot] <= vmax_v;
      col_min_q[vsb_out.cslot] <= vmin_v;
    end
  end

  always_comb begin
    logic [SW-1:0] ofs;
    logic          cur;
    logic          inc;
    for (int j = 0; j < L; j++) begin
      cur = (SW'(j) == vsb_out.cslot);
      ofs = vsb_out.cslot - SW'(j);
      inc = (SW+WB)'(ofs) < (SW+WB)'(w_eff);
      hmax_in[j] = !inc ? '0 : (cur ? vmax_v : col_max_q[j]);
      hmin_in[j] = !inc ? '1 : (cur ? vmin_v : col_min_q[j]);
    end
  end

  assign hsb_in = '{valid: vsb_out.valid, flags: vsb_out.flags};

  wmrs_minmax_tree #(
    .N   (L),
    .W   (PW),
    .SBW ($bits(hsb_t))
  ) u_horz_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .max_i  (hmax_in),
    .min_i  (hmin_in),
    .sb_i   (hsb_in),
    .max_o  (hmax_h),
    .min_o  (hmin_h),
    .sb_o   (hsb_out)
  );

  always_comb begin
    diff      = hmax_h - hmin_h;
    range_val = PIX_W'(diff);
    best_base = hsb_out.flags.rst_best ? RANGE_TOP : best_q;
    best_new  = (hsb_out.flags.h_do && (range_val < best_base)) ? range_val : best_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      best_q      <= RANGE_TOP;
    end else if (advance) begin
      out_valid_q <= hsb_out.valid && hsb_out.flags.h_do;
      if (hsb_out.valid) begin
        best_q <= hsb_out.flags.wrap ? RANGE_TOP : best_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.window_range <= range_val;
      out_q.best_range   <= best_new;
      out_q.frame_done   <= hsb_out.flags.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/window_min_range_square_checker.sv @@
// Port-level checker for the window min/max range block, bound to the top level.
// Depends on wmrs_pkg and the assertion macro header.
`include "window_min_range_square_assert.svh"

module window_min_range_square_checker import wmrs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input res_out_t out_data_o
);

  `WMRS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `WMRS_ASSERT_SAME(a_best_le_range, out_valid_o, out_data_o.best_range <= out_data_o.window_range)
  `WMRS_ASSERT_SAME(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o)
  `WMRS_ASSERT_SAME(a_empty_takes_input, !out_valid_o, in_ready_o)

endmodule

bind window_min_range_square window_min_range_square_checker u_checker (.*);

@@ bench/tb_window_min_range_square.sv @@
`timescale 1ns / 1ps
// Self-checking bench for window_min_range_square: short corner-case frames, then random
// frames under random source gaps and sink stalls. Depends on wmrs_pkg and the block's RTL.
module tb_window_min_range_square;
  import wmrs_pkg::*;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_WINDOW   = 16;
  localparam int SETTLE_CYC   = 20;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1050;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_e;
  typedef enum int {PIX_ANY, PIX_NARROW, PIX_RAIL, PIX_FLAT} pix_style_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pix_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  res_out_t              out_data;

  // Shadow registers and state of the square-range predictor.
  logic [ROWS_W-1:0] rows_reg = 16'd1;
  logic [COLS_W-1:0] cols_reg = 11'd1;
  logic [WIN_W-1:0]  win_reg = 5'd1;
  logic [PIX_W-1:0]  line_mem [MAX_WINDOW*MAX_COLS];
  logic [PIX_W-1:0]  col_hi [MAX_WINDOW];
  logic [PIX_W-1:0]  col_lo [MAX_WINDOW];
  int unsigned       row_pos = 0;
  int unsigned       col_pos = 0;
  logic [PIX_W-1:0]  best_span = RANGE_TOP;

  res_out_t    squares_due[$];
  res_out_t    due_square;
  idle_mode_e  src_mode = IDLE_FULL;
  idle_mode_e  sink_mode = IDLE_FULL;
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned squares_seen = 0;
  int unsigned configs_run = 0;
  int unsigned cycles = 0;

  window_min_range_square dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("window_min_range_square regression: fail");
      $finish;
    end
  end

  function automatic int unsigned eff_size(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned draw_wait(idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 14);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(pix_style_e style, logic [PIX_W-1:0] base);
    case (style)
      PIX_ANY:    return PIX_W'($urandom());
      PIX_NARROW: return base + PIX_W'($urandom_range(0, 15));
      PIX_RAIL: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return RANGE_TOP;
          default: return PIX_W'($urandom());
        endcase
      end
      default:    return base ^ PIX_W'($urandom_range(0, 1));
    endcase
  endfunction

  // Places one pixel and queues the square result it completes, if any.
  function automatic void predict_square(pix_in_t item);
    int unsigned rows, cols, win, r, c, k, slot;
    logic [PIX_W-1:0] v, vhi, vlo, hhi, hlo, span;
    res_out_t res;
    rows = eff_size(rows_reg, 16'hffff);
    cols = eff_size(cols_reg, MAX_COLS);
    win = eff_size(win_reg, MAX_WINDOW);
    if (item.frame_start) begin
      row_pos = 0;
      col_pos = 0;
      best_span = RANGE_TOP;
    end
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    line_mem[(r % MAX_WINDOW) * MAX_COLS + c] = item.pixel;
    if (r + 1 >= win) begin
      vhi = '0;
      vlo = '1;
      for (k = 0; k < win; k++) begin
        v = line_mem[((r - k) % MAX_WINDOW) * MAX_COLS + c];
        if (v > vhi) vhi = v;
        if (v < vlo) vlo = v;
      end
      col_hi[c % MAX_WINDOW] = vhi;
      col_lo[c % MAX_WINDOW] = vlo;
      if (c + 1 >= win) begin
        hhi = '0;
        hlo = '1;
        for (k = 0; k < win; k++) begin
          slot = (c - k) % MAX_WINDOW;
          if (col_hi[slot] > hhi) hhi = col_hi[slot];
          if (col_lo[slot] < hlo) hlo = col_lo[slot];
        end
        span = (hhi >= hlo) ? hhi - hlo : '0;
        if (span < best_span) best_span = span;
        res.window_range = span;
        res.best_range = best_span;
        res.frame_done = (r + 1 == rows) && (c + 1 == cols);
        squares_due.push_back(res);
      end
    end
    if (c + 1 < cols) begin
      col_pos = c + 1;
      row_pos = r;
    end else if (r + 1 < rows) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = 0;
      row_pos = 0;
      best_span = RANGE_TOP;
    end
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] value, input logic restart);
    int unsigned gap;
    logic hold;
    pix_in_t item;
    gap = draw_wait(src_mode);
    hold = ($urandom_range(0, 99) == 0);
    if (hold && gap == 0) gap = 1;
    if (gap != 0) begin
      in_valid <= 1'b0;
      if (hold) begin
        while (squares_due.size() != 0) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    item.pixel = value;
    item.frame_start = restart;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_square(item);
    pixels_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (squares_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic program_frame(input logic [ROWS_W-1:0] rows, input logic [COLS_W-1:0] cols,
                               input logic [WIN_W-1:0] win);
    cfg_we <= 1'b1;
    cfg_idx <= REG_FRAME_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    rows_reg = rows;
    cfg_idx <= REG_FRAME_COLS;
    cfg_wdata <= {{(CFG_DATA_W-COLS_W){1'b0}}, cols};
    @(posedge clk);
    cols_reg = cols;
    cfg_idx <= REG_WINDOW_SIZE;
    cfg_wdata <= {{(CFG_DATA_W-WIN_W){1'b0}}, win};
    @(posedge clk);
    win_reg = win;
    cfg_we <= 1'b0;
    configs_run++;
  endtask

  // Runs whole frames of one setting; a frame may be cut short by the next frame start.
  task automatic run_frames(input logic [ROWS_W-1:0] rows, input logic [COLS_W-1:0] cols,
                            input logic [WIN_W-1:0] win, input int unsigned frames,
                            input int unsigned pixel_cap);
    int unsigned per_frame, len, f, i, sent;
    pix_style_e style;
    logic [PIX_W-1:0] base;
    logic restart;
    drain_results();
    program_frame(rows, cols, win);
    per_frame = eff_size(rows, 16'hffff) * eff_size(cols, MAX_COLS);
    style = pix_style_e'($urandom_range(0, 3));
    base = PIX_W'($urandom());
    sent = 0;
    restart = 1'b1;
    for (f = 0; f < frames && sent < pixel_cap; f++) begin
      len = per_frame;
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, per_frame);
      for (i = 0; i < len && sent < pixel_cap; i++) begin
        send_pixel(draw_pixel(style, base),
                   (i == 0) && (restart || ($urandom_range(0, 1) == 1)));
        sent++;
      end
      restart = (len != per_frame);
    end
  endtask

  task automatic test_reset_defaults();
    send_pixel(31'h0000_1234, 1'b0);
    send_pixel(RANGE_TOP, 1'b1);
  endtask

  task automatic test_zero_registers();
    drain_results();
    program_frame('0, '0, '0);
    send_pixel(PIX_W'($urandom()), 1'b0);
  endtask

  task automatic test_full_scale_pixels();
    drain_results();
    program_frame(16'd2, 11'd2, 5'd2);
    send_pixel('0, 1'b1);
    send_pixel(RANGE_TOP, 1'b0);
    send_pixel(RANGE_TOP, 1'b0);
    send_pixel('0, 1'b0);
    // The second frame follows the end-of-frame wrap with no frame start.
    send_pixel(RANGE_TOP, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(RANGE_TOP, 1'b0);
  endtask

  task automatic test_window_over_frame();
    int unsigned i;
    drain_results();
    program_frame(16'd2, 11'd2, 5'd31);
    for (i = 0; i < 4; i++) send_pixel(PIX_W'($urandom()), i == 0);
  endtask

  task automatic test_restart_mid_frame();
    int unsigned i;
    drain_results();
    program_frame(16'd2, 11'd2, 5'd2);
    send_pixel(PIX_W'($urandom()), 1'b1);
    for (i = 0; i < 4; i++) send_pixel(PIX_W'($urandom()), i == 0);
  endtask

  task automatic test_position_clamp();
    int unsigned i;
    drain_results();
    program_frame(16'd3, 11'd3, 5'd1);
    for (i = 0; i < 4; i++) send_pixel(PIX_W'($urandom()), i == 0);
    // Shrinking the frame leaves the position past the last row and column.
    drain_results();
    program_frame(16'd1, 11'd1, 5'd1);
    send_pixel(PIX_W'($urandom()), 1'b0);
    send_pixel(PIX_W'($urandom()), 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned phase, lim;
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
    logic [WIN_W-1:0] win;
    phase = 0;
    while (pixels_sent < RANDOM_ITEMS || phase < 9) begin
      src_mode = idle_mode_e'($urandom_range(0, 2));
      sink_mode = idle_mode_e'($urandom_range(0, 2));
      if (phase == 2) begin
        src_mode = IDLE_SPARSE;
        sink_mode = IDLE_SPARSE;
        run_frames(16'($urandom_range(0, 1)), 11'($urandom_range(1024, 2047)),
                   5'($urandom_range(0, 1)), 1, 160);
      end else if (phase == 5) begin
        run_frames(16'hffff, 11'($urandom_range(1, 3)), 5'($urandom_range(1, 2)),
                   1, 48);
      end else if (phase == 8) begin
        run_frames(16'($urandom_range(16, 17)), 11'($urandom_range(16, 17)),
                   5'($urandom_range(16, 31)), 1, 400);
      end else begin
        rows = 16'($urandom_range(1, 8));
        cols = 11'($urandom_range(1, 8));
        if ($urandom_range(0, 15) == 0) rows = '0;
        if ($urandom_range(0, 15) == 0) cols = '0;
        lim = (eff_size(rows, 8) < eff_size(cols, 8)) ? eff_size(rows, 8) : eff_size(cols, 8);
        win = 5'($urandom_range(1, lim));
        if ($urandom_range(0, 7) == 0) win = 5'($urandom_range(0, 31));
        run_frames(rows, cols, win, $urandom_range(1, 4), 64);
      end
      phase++;
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(sink_mode);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      squares_seen++;
      if (squares_due.size() == 0) begin
        $display("%0t: result with none pending: expected nothing, actual %p", $time,
                 out_data);
        errors++;
      end else begin
        due_square = squares_due.pop_front();
        if (out_data.window_range !== due_square.window_range) begin
          $display("%0t: window_range expected %0h actual %0h", $time,
                   due_square.window_range, out_data.window_range);
          errors++;
        end
        if (out_data.best_range !== due_square.best_range) begin
          $display("%0t: best_range expected %0h actual %0h", $time,
                   due_square.best_range, out_data.best_range);
          errors++;
        end
        if (out_data.frame_done !== due_square.frame_done) begin
          $display("%0t: frame_done expected %0b actual %0b", $time,
                   due_square.frame_done, out_data.frame_done);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_registers();
    test_full_scale_pixels();
    test_window_over_frame();
    test_restart_mid_frame();
    test_position_clamp();
    test_random_frames();
    drain_results();
    $display("Checked %0d square results from %0d pixel transfers over %0d frame setups,",
             squares_seen, pixels_sent, configs_run);
    $display("including full-scale pixels, clamped registers, wide rows and the widest window.");
    if (errors == 0 && squares_due.size() == 0) begin
      $display("window_min_range_square regression: pass");
    end else begin
      $display("window_min_range_square regression: fail");
    end
    $finish;
  end

endmodule
